// ----- src/estm_pkg.sv -----
`default_nettype none

package estm_pkg;

   // CORDIC chain depth and stage index width
   localparam int CORDIC_STAGES = 16;
   localparam int STAGE_W       = $clog2(CORDIC_STAGES);

   // pipeline depth from word accept to result: cell chain plus six matrix stages
   localparam int LATENCY = CORDIC_STAGES + 6;

   // CORDIC gain 0.60725... in Q2.30
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

   // arctangent of 2^-i, 2^32 units per turn
   localparam logic signed [31:0] ATAN_TBL [CORDIC_STAGES] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
   };

   typedef logic [STAGE_W-1:0] stage_type;

   // input word
   typedef struct packed {
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   // result word, Q16.16 entries
   typedef struct packed {
      logic signed [31:0] col0_row0;
      logic signed [31:0] col0_row1;
      logic signed [31:0] col0_row2;
      logic signed [31:0] col1_row0;
      logic signed [31:0] col1_row1;
      logic signed [31:0] col1_row2;
      logic signed [31:0] col2_row0;
      logic signed [31:0] col2_row1;
      logic signed [31:0] col2_row2;
      logic signed [31:0] col3_row0;
      logic signed [31:0] col3_row1;
      logic signed [31:0] col3_row2;
   } rsp_type;

   // fields that ride along with the rotators
   typedef struct packed {
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } pass_type;

   // one rotator: Q2.30 vector, residual angle, half-turn fold flag
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               flip;
   } rot_type;

   // what one cell hands to the next: rotators for X, Y, Z plus the pass fields
   typedef struct packed {
      rot_type [2:0] rot;
      pass_type      pass;
   } cord_type;

endpackage

`default_nettype wire

// ----- src/estm_cordic_cell.sv -----
`default_nettype none

module estm_cordic_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire estm_pkg::stage_type  stage,
   input  wire logic                 src_valid,
   input  wire estm_pkg::cord_type   src_data,
   output logic                      dst_valid,
   output estm_pkg::cord_type        dst_data
);

   logic               valid_ff, valid_in;
   estm_pkg::cord_type data_ff, data_in;

   // one micro-rotation for each of the three angles
   always_comb begin
      logic signed [31:0] xs, ys, zs, dx, dy, atan;
      data_in  = src_data;
      valid_in = src_valid;
      atan     = estm_pkg::ATAN_TBL[stage];
      for (int k = 0; k < 3; k++) begin
         xs = src_data.rot[k].x;
         ys = src_data.rot[k].y;
         zs = src_data.rot[k].z;
         dx = ys >>> stage;
         dy = xs >>> stage;
         if (!zs[31]) begin
            data_in.rot[k].x = xs - dx;
            data_in.rot[k].y = ys + dy;
            data_in.rot[k].z = zs - atan;
         end else begin
            data_in.rot[k].x = xs + dx;
            data_in.rot[k].y = ys - dy;
            data_in.rot[k].z = zs + atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign dst_valid = valid_ff;
   assign dst_data  = data_ff;

endmodule

`default_nettype wire

// ----- src/estm_matrix_core.sv -----
`default_nettype none

module estm_matrix_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                src_valid,
   input  wire estm_pkg::cord_type  src_data,
   output logic                     rsp_valid,
   output estm_pkg::rsp_type        rsp_data
);

   // pair product slots
   localparam int P_C2C3 = 0;
   localparam int P_C2S3 = 1;
   localparam int P_C1S3 = 2;
   localparam int P_C3S1 = 3;
   localparam int P_C1C3 = 4;
   localparam int P_S1S3 = 5;
   localparam int P_C2S1 = 6;
   localparam int P_C1C2 = 7;
   localparam int P_S1S2 = 8;
   localparam int P_C1S2 = 9;
   localparam int NUM_PAIR = 10;
   localparam int NUM_KEEP = 8;

   // triple product slots
   localparam int T_S1S2C3 = 0;
   localparam int T_S1S2S3 = 1;
   localparam int T_C1S2C3 = 2;
   localparam int T_C1S2S3 = 3;
   localparam int NUM_TRIP = 4;

   localparam int NUM_ENT = 9;

   // round Q2.30 to Q2.15, clamp to +-1.0, undo the half-turn fold
   function automatic logic signed [16:0] round_q15(input logic signed [31:0] v,
                                                    input logic neg);
      logic signed [32:0] sum;
      logic signed [17:0] sh;
      logic signed [16:0] r;
      sum = {v[31], v} + 33'sd16384;
      sh  = sum[32:15];
      if (sh > 18'sd32768) begin
         r = 17'sd32768;
      end else if (sh < -18'sd32768) begin
         r = -17'sd32768;
      end else begin
         r = sh[16:0];
      end
      if (neg) begin
         r = -r;
      end
      return r;
   endfunction

   function automatic logic signed [33:0] mul17(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
      logic signed [33:0] r;
      r = a * b;
      return r;
   endfunction

   function automatic logic signed [48:0] mul32x17(input logic signed [31:0] a,
                                                   input logic signed [16:0] b);
      logic signed [48:0] r;
      r = a * b;
      return r;
   endfunction

   function automatic logic signed [63:0] mul16x48(input logic signed [15:0] a,
                                                   input logic signed [47:0] b);
      logic signed [63:0] r;
      r = a * b;
      return r;
   endfunction

   // pair product times 2^15, onto the 45-fraction-bit scale
   function automatic logic signed [47:0] shl15(input logic signed [31:0] v);
      return {v[31], v, 15'b0};
   endfunction

   // Q11.53 down to Q16.16 with round half up; |scale * e| < 2^61 keeps
   // the shifted value inside 27 bits, so sign extension to 32 bits needs no clamp
   function automatic logic signed [31:0] to_q16(input logic signed [63:0] p);
      logic signed [63:0] sum;
      logic signed [26:0] r;
      sum = p + (64'sd1 <<< 36);
      r   = sum[63:37];
      return {{5{r[26]}}, r};
   endfunction

   logic [4:0]         vld_ff, vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [16:0] sin_ff [3], sin_in [3];
   logic signed [16:0] cos_ff [3], cos_in [3];
   estm_pkg::pass_type pass_r_ff;

   logic signed [31:0] pair_ff [NUM_PAIR], pair_in [NUM_PAIR];
   logic signed [16:0] s2_p1_ff, c3_p1_ff, s3_p1_ff;
   estm_pkg::pass_type pass_p1_ff;

   logic signed [46:0] trip_ff [NUM_TRIP], trip_in [NUM_TRIP];
   logic signed [31:0] keep_ff [NUM_KEEP];
   logic signed [16:0] s2_p2_ff;
   estm_pkg::pass_type pass_p2_ff;

   logic signed [47:0] ent_ff [NUM_ENT], ent_in [NUM_ENT];
   estm_pkg::pass_type pass_p3_ff;

   logic signed [63:0] prod_ff [NUM_ENT], prod_in [NUM_ENT];
   estm_pkg::pass_type pass_p4_ff;

   estm_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   assign vld_in       = {vld_ff[3:0], src_valid};
   assign rsp_valid_in = vld_ff[4];

   // stage R: sine and cosine of each angle
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sin_in[k] = round_q15(src_data.rot[k].y, src_data.rot[k].flip);
         cos_in[k] = round_q15(src_data.rot[k].x, src_data.rot[k].flip);
      end
   end

   // stage P1: two-factor products (1 = X, 2 = Y, 3 = Z)
   always_comb begin
      logic signed [33:0] m [NUM_PAIR];
      m[P_C2C3] = mul17(cos_ff[1], cos_ff[2]);
      m[P_C2S3] = mul17(cos_ff[1], sin_ff[2]);
      m[P_C1S3] = mul17(cos_ff[0], sin_ff[2]);
      m[P_C3S1] = mul17(cos_ff[2], sin_ff[0]);
      m[P_C1C3] = mul17(cos_ff[0], cos_ff[2]);
      m[P_S1S3] = mul17(sin_ff[0], sin_ff[2]);
      m[P_C2S1] = mul17(cos_ff[1], sin_ff[0]);
      m[P_C1C2] = mul17(cos_ff[0], cos_ff[1]);
      m[P_S1S2] = mul17(sin_ff[0], sin_ff[1]);
      m[P_C1S2] = mul17(cos_ff[0], sin_ff[1]);
      for (int k = 0; k < NUM_PAIR; k++) begin
         pair_in[k] = m[k][31:0];
      end
   end

   // stage P2: three-factor products
   always_comb begin
      logic signed [48:0] m [NUM_TRIP];
      m[T_S1S2C3] = mul32x17(pair_ff[P_S1S2], c3_p1_ff);
      m[T_S1S2S3] = mul32x17(pair_ff[P_S1S2], s3_p1_ff);
      m[T_C1S2C3] = mul32x17(pair_ff[P_C1S2], c3_p1_ff);
      m[T_C1S2S3] = mul32x17(pair_ff[P_C1S2], s3_p1_ff);
      for (int k = 0; k < NUM_TRIP; k++) begin
         trip_in[k] = m[k][46:0];
      end
   end

   // stage P3: rotation entries with 45 fraction bits
   always_comb begin
      logic signed [47:0] t [NUM_TRIP];
      for (int k = 0; k < NUM_TRIP; k++) begin
         t[k] = {trip_ff[k][46], trip_ff[k]};
      end
      ent_in[0] = shl15(keep_ff[P_C2C3]);
      ent_in[1] = -shl15(keep_ff[P_C2S3]);
      ent_in[2] = {s2_p2_ff[16], s2_p2_ff, 30'b0};
      ent_in[3] = shl15(keep_ff[P_C1S3]) + t[T_S1S2C3];
      ent_in[4] = shl15(keep_ff[P_C1C3]) - t[T_S1S2S3];
      ent_in[5] = -shl15(keep_ff[P_C2S1]);
      ent_in[6] = shl15(keep_ff[P_S1S3]) - t[T_C1S2C3];
      ent_in[7] = shl15(keep_ff[P_C3S1]) + t[T_C1S2S3];
      ent_in[8] = shl15(keep_ff[P_C1C2]);
   end

   // stage P4: scale each column
   always_comb begin
      for (int k = 0; k < NUM_ENT; k++) begin
         if (k < 3) begin
            prod_in[k] = mul16x48(pass_p3_ff.scale_x, ent_ff[k]);
         end else if (k < 6) begin
            prod_in[k] = mul16x48(pass_p3_ff.scale_y, ent_ff[k]);
         end else begin
            prod_in[k] = mul16x48(pass_p3_ff.scale_z, ent_ff[k]);
         end
      end
   end

   // stage P5: round to Q16.16, attach position
   always_comb begin
      rsp_data_in.col0_row0 = to_q16(prod_ff[0]);
      rsp_data_in.col0_row1 = to_q16(prod_ff[1]);
      rsp_data_in.col0_row2 = to_q16(prod_ff[2]);
      rsp_data_in.col1_row0 = to_q16(prod_ff[3]);
      rsp_data_in.col1_row1 = to_q16(prod_ff[4]);
      rsp_data_in.col1_row2 = to_q16(prod_ff[5]);
      rsp_data_in.col2_row0 = to_q16(prod_ff[6]);
      rsp_data_in.col2_row1 = to_q16(prod_ff[7]);
      rsp_data_in.col2_row2 = to_q16(prod_ff[8]);
      rsp_data_in.col3_row0 = pass_p4_ff.pos_x;
      rsp_data_in.col3_row1 = pass_p4_ff.pos_y;
      rsp_data_in.col3_row2 = pass_p4_ff.pos_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sin_ff     <= sin_in;
      cos_ff     <= cos_in;
      pass_r_ff  <= src_data.pass;
      pair_ff    <= pair_in;
      s2_p1_ff   <= sin_ff[1];
      c3_p1_ff   <= cos_ff[2];
      s3_p1_ff   <= sin_ff[2];
      pass_p1_ff <= pass_r_ff;
      trip_ff    <= trip_in;
      for (int k = 0; k < NUM_KEEP; k++) begin
         keep_ff[k] <= pair_ff[k];
      end
      s2_p2_ff    <= s2_p1_ff;
      pass_p2_ff  <= pass_p1_ff;
      ent_ff      <= ent_in;
      pass_p3_ff  <= pass_p2_ff;
      prod_ff     <= prod_in;
      pass_p4_ff  <= pass_p3_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sine and cosine never leave +-1.0 after rounding
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> (sin_ff[0] <= 17'sd32768 && sin_ff[0] >= -17'sd32768 &&
                     cos_ff[0] <= 17'sd32768 && cos_ff[0] >= -17'sd32768 &&
                     sin_ff[1] <= 17'sd32768 && sin_ff[1] >= -17'sd32768 &&
                     cos_ff[1] <= 17'sd32768 && cos_ff[1] >= -17'sd32768 &&
                     sin_ff[2] <= 17'sd32768 && sin_ff[2] >= -17'sd32768 &&
                     cos_ff[2] <= 17'sd32768 && cos_ff[2] >= -17'sd32768))
      else $error("sine or cosine outside +-1.0");

endmodule

`default_nettype wire

// ----- src/euler_scale_translate_matrix_unit.sv -----
`default_nettype none

// channel   ports                      word
// -------   -----                      ----
// request   start, busy, req_data      angles, scales, position (req_type)
// result    rsp_valid, rsp_data        3x4 transform, column-major (rsp_type)
//
// One word accepted per cycle while busy is low; busy is high during reset and
// in the cycle after it. Each result shows on rsp_* for one cycle, after its word
// has passed 16 CORDIC cells, then round, pair products, triple
// products, entry sums, scale multiply and the output register.
// Reset (synchronous) drops all words in flight. The receiver cannot stall.

module euler_scale_translate_matrix_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire estm_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output estm_pkg::rsp_type       rsp_data
);

   logic               busy_ff;
   estm_pkg::cord_type load_data;
   logic               chain_valid [estm_pkg::CORDIC_STAGES+1];
   estm_pkg::cord_type chain_data  [estm_pkg::CORDIC_STAGES+1];

   // load the rotators: fold angles in the left half-plane by half a turn
   always_comb begin
      logic signed [15:0] ang [3];
      logic               flip;
      ang[0] = req_data.angle_x;
      ang[1] = req_data.angle_y;
      ang[2] = req_data.angle_z;
      for (int k = 0; k < 3; k++) begin
         flip = ang[k][15] ^ ang[k][14];
         load_data.rot[k].x    = estm_pkg::CORDIC_GAIN_Q30;
         load_data.rot[k].y    = '0;
         load_data.rot[k].z    = {ang[k][15] ^ flip, ang[k][14:0], 16'b0};
         load_data.rot[k].flip = flip;
      end
      load_data.pass.scale_x = req_data.scale_x;
      load_data.pass.scale_y = req_data.scale_y;
      load_data.pass.scale_z = req_data.scale_z;
      load_data.pass.pos_x   = req_data.pos_x;
      load_data.pass.pos_y   = req_data.pos_y;
      load_data.pass.pos_z   = req_data.pos_z;
   end

   assign chain_data[0]  = load_data;
   assign chain_valid[0] = start && !busy_ff;

   // CORDIC cell chain
   for (genvar k = 0; k < estm_pkg::CORDIC_STAGES; k++) begin : g_cell
      estm_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage     (estm_pkg::stage_type'(k)),
         .src_valid (chain_valid[k]),
         .src_data  (chain_data[k]),
         .dst_valid (chain_valid[k+1]),
         .dst_data  (chain_data[k+1])
      );
   end

   // rounding, products, scaling, output register
   estm_matrix_core u_matrix (
      .clock     (clock),
      .reset     (reset),
      .src_valid (chain_valid[estm_pkg::CORDIC_STAGES]),
      .src_data  (chain_data[estm_pkg::CORDIC_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // hold off the first word until the pipeline is clean
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, estm_pkg::LATENCY))
      else $error("result without an accepted word");

   a_pos_passthrough: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.col3_row0 == $past(req_data.pos_x, estm_pkg::LATENCY) &&
                     rsp_data.col3_row2 == $past(req_data.pos_z, estm_pkg::LATENCY)))
      else $error("position column misaligned with its word");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int GAP_MAX      = 13;
   localparam int RANDOM_WORDS = 950;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int NUM_DIRECTED = 16;

   // rotator start value and arctangent steps, 2^32 per turn
   localparam longint GAIN_Q30 = 652032874;
   localparam longint ATAN_TURN32 [16] = '{
      536870912, 316933406, 167458907, 85004756,
      42667331,  21354465,  10679838,  5340245,
      2670163,   1335087,   667544,    333772,
      166886,    83443,     41722,     20861
   };
   localparam longint K15 = 32768;
   localparam longint K30 = longint'(1) << 30;

   // directed row: zero_rot marks rows whose rotation entries are all zero (scales zero)
   typedef struct packed {
      logic              zero_rot;
      estm_pkg::req_type word;
   } dir_row_type;

   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      {1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {1'b0, 16'h4000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100,
             32'h0001_0000, 32'h0000_0000, 32'h0000_0000},
      {1'b0, 16'h0000, 16'h4000, 16'h0000, 16'h0100, 16'h0100, 16'h0100,
             32'h0000_0000, 32'h0001_0000, 32'h0000_0000},
      {1'b0, 16'h0000, 16'h0000, 16'h4000, 16'h0100, 16'h0100, 16'h0100,
             32'h0000_0000, 32'h0000_0000, 32'h0001_0000},
      {1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h0100, 16'h0100, 16'h0100,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {1'b0, 16'hC000, 16'hC000, 16'hC000, 16'h0100, 16'h0100, 16'h0100,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {1'b0, 16'h3FFF, 16'h4001, 16'hBFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000},
      {1'b0, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8000, 16'h8000, 16'h8000,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {1'b0, 16'h2000, 16'h2000, 16'h2000, 16'h7FFF, 16'h8000, 16'h0001,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {1'b0, 16'hE000, 16'h6000, 16'hA000, 16'hFF00, 16'h0100, 16'hFFFF,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {1'b1, 16'h1234, 16'hABCD, 16'h4000, 16'h0000, 16'h0000, 16'h0000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
      {1'b1, 16'h8000, 16'h4000, 16'hC000, 16'h0000, 16'h0000, 16'h0000,
             32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF},
      {1'b0, 16'hBFFF, 16'hC001, 16'h3FFF, 16'h8000, 16'h7FFF, 16'h8000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      {1'b0, 16'h0001, 16'hFFFF, 16'h8001, 16'h0001, 16'hFFFF, 16'h0080,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      {1'b0, 16'h5555, 16'hAAAA, 16'h1111, 16'h1000, 16'hF000, 16'h0001,
             32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000}
   };

   string field_name [12] = '{
      "col0_row0", "col0_row1", "col0_row2", "col1_row0", "col1_row1", "col1_row2",
      "col2_row0", "col2_row1", "col2_row2", "col3_row0", "col3_row1", "col3_row2"
   };

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   estm_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_valid;
   estm_pkg::rsp_type rsp_data;

   // expectation that goes with the word on req_data
   estm_pkg::rsp_type word_want = '0;
   estm_pkg::rsp_type matrix_queue [$];
   int                fail_count  = 0;
   int                cycle_count = 0;

   euler_scale_translate_matrix_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Q2.30 value rounded to Q2.15, clamped to +-1.0
   function automatic longint round_q15(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32768) r = 32768;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   // sine and cosine of a binary angle: fold to the right half plane, 16 rotations
   function automatic void sin_cos(input logic [15:0] angle,
                                   output longint sin_q15, output longint cos_q15);
      logic [31:0] phase;
      logic        flip;
      longint      x, y, z, dx, dy;
      int          i;
      phase = {angle, 16'h0000};
      flip  = (phase - 32'h4000_0000) < 32'h8000_0000;
      if (flip) phase = phase + 32'h8000_0000;
      x = GAIN_Q30;
      y = 0;
      z = longint'(signed'(phase));
      for (i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURN32[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURN32[i];
         end
      end
      cos_q15 = round_q15(x);
      sin_q15 = round_q15(y);
      if (flip) begin
         cos_q15 = -cos_q15;
         sin_q15 = -sin_q15;
      end
   endfunction

   // Q8.8 scale times a 45-fraction-bit term, rounded to Q16.16, saturated
   function automatic logic [31:0] scaled_entry(input longint scale, input longint e45);
      longint r;
      r = (scale * e45 + (longint'(1) << 36)) >>> 37;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   function automatic estm_pkg::rsp_type predict_matrix(input estm_pkg::req_type w);
      longint            s1, c1, s2, c2, s3, c3, sx, sy, sz;
      estm_pkg::rsp_type m;
      sin_cos(w.angle_x, s1, c1);
      sin_cos(w.angle_y, s2, c2);
      sin_cos(w.angle_z, s3, c3);
      sx = longint'(w.scale_x);
      sy = longint'(w.scale_y);
      sz = longint'(w.scale_z);
      m.col0_row0 = scaled_entry(sx, c2 * c3 * K15);
      m.col0_row1 = scaled_entry(sx, -(c2 * s3) * K15);
      m.col0_row2 = scaled_entry(sx, s2 * K30);
      m.col1_row0 = scaled_entry(sy, c1 * s3 * K15 + c3 * s1 * s2);
      m.col1_row1 = scaled_entry(sy, c1 * c3 * K15 - s1 * s2 * s3);
      m.col1_row2 = scaled_entry(sy, -(c2 * s1) * K15);
      m.col2_row0 = scaled_entry(sz, s1 * s3 * K15 - c1 * c3 * s2);
      m.col2_row1 = scaled_entry(sz, c3 * s1 * K15 + c1 * s2 * s3);
      m.col2_row2 = scaled_entry(sz, c1 * c2 * K15);
      m.col3_row0 = w.pos_x;
      m.col3_row1 = w.pos_y;
      m.col3_row2 = w.pos_z;
      return m;
   endfunction

   // compare a result word with the oldest expectation, field by field
   task automatic check_matrix(input estm_pkg::rsp_type got);
      estm_pkg::rsp_type want;
      int                k;
      if (matrix_queue.size() == 0) begin
         $error("result word with no expectation waiting");
         fail_count++;
      end else begin
         want = matrix_queue.pop_front();
         for (k = 0; k < 12; k++) begin
            if (got[383 - 32*k -: 32] !== want[383 - 32*k -: 32]) begin
               $error("%s: expected %0d, got %0d", field_name[k],
                      $signed(want[383 - 32*k -: 32]), $signed(got[383 - 32*k -: 32]));
               fail_count++;
            end
         end
      end
   endtask

   // monitor: results first, then the word accepted at this edge
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) check_matrix(rsp_data);
      if (!reset && start && busy === 1'b0) matrix_queue.push_back(word_want);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // back-to-back stretches with no gaps, otherwise a random idle gap up to GAP_MAX per word
   function automatic int draw_gap(input int n);
      if ((n / 100) % 3 == 2) return 0;
      return $urandom_range(0, GAP_MAX);
   endfunction

   // hold a word on req_data until the block takes it
   task automatic send_word(input estm_pkg::req_type w, input estm_pkg::rsp_type want,
                            input int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start     <= 1'b1;
      req_data  <= w;
      word_want <= want;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // random angle: mostly anywhere, sometimes right at a quarter-turn boundary
   function automatic logic [15:0] random_angle();
      if ($urandom_range(0, 3) == 0)
         return {2'($urandom_range(0, 3)), 14'h0000} + 16'($urandom_range(0, 6)) - 16'd3;
      return 16'($urandom);
   endfunction

   // random scale: mostly any Q8.8, sometimes near +-1.0
   function automatic logic [15:0] random_scale();
      if ($urandom_range(0, 3) == 0)
         return ($urandom_range(0, 1) ? 16'h0100 : 16'hFF00) + 16'($urandom_range(0, 31)) - 16'd16;
      return 16'($urandom);
   endfunction

   initial begin
      dir_row_type       row;
      estm_pkg::req_type w;
      estm_pkg::rsp_type want;
      int                n;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (n = 0; n < NUM_DIRECTED; n++) begin
         row = DIRECTED[n];
         w   = row.word;
         if (row.zero_rot) begin
            want           = '0;
            want.col3_row0 = w.pos_x;
            want.col3_row1 = w.pos_y;
            want.col3_row2 = w.pos_z;
         end else begin
            want = predict_matrix(w);
         end
         send_word(w, want, draw_gap(n + 200));
      end

      // random words
      for (n = 0; n < RANDOM_WORDS; n++) begin
         w.angle_x = random_angle();
         w.angle_y = random_angle();
         w.angle_z = random_angle();
         w.scale_x = random_scale();
         w.scale_y = random_scale();
         w.scale_z = random_scale();
         w.pos_x   = $urandom;
         w.pos_y   = $urandom;
         w.pos_z   = $urandom;
         send_word(w, predict_matrix(w), draw_gap(n));
      end

      @(negedge clock);
      start <= 1'b0;

      // drain
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
